// File: hw/rtl/decimal_string_to_fixed_point_macros.svh
// assertion macros for the decimal string to fixed point parser
`ifndef DECIMAL_STRING_TO_FIXED_POINT_MACROS_SVH
`define DECIMAL_STRING_TO_FIXED_POINT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DSFP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DSFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/dsfp_pkg.sv
// shared types and constants for the decimal string to fixed point parser
package dsfp_pkg;

    localparam int unsigned MAX_DIGITS = 18;
    localparam int unsigned ACC_W      = 60;
    localparam int unsigned VALUE_W    = 61;
    localparam int unsigned PREC_W     = 5;
    localparam int unsigned CNT_W      = 5;
    localparam int unsigned STATUS_W   = 3;

    localparam logic [PREC_W-1:0] PREC_RESET = 5'd8;
    localparam logic [PREC_W-1:0] PREC_MAX   = 5'd18;

    localparam logic [ACC_W-1:0] MAG_LIMIT       = 60'd999999999999999999;
    localparam logic [ACC_W-1:0] MAG_LIMIT_DIV10 = 60'd99999999999999999;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [STATUS_W-1:0] STATUS_OK            = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY         = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_DOUBLE_POINT  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_TOO_MANY_DIG  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_TOO_MANY_FRAC = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CHAR      = 3'd5;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW      = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHAR,
        ST_SCALE,
        ST_FINISH
    } dsfp_state_t;

endpackage

// File: hw/rtl/dsfp_mul10_add.sv
// shared shift-add unit: times ten plus one decimal digit
module dsfp_mul10_add (
    input  logic [dsfp_pkg::ACC_W-1:0] a,
    input  logic [3:0]                 digit,
    output logic [dsfp_pkg::ACC_W-1:0] y
);
    import dsfp_pkg::*;

    assign y = (a << 3) + (a << 1) + {{(ACC_W-4){1'b0}}, digit};

endmodule

// File: hw/rtl/decimal_string_to_fixed_point.sv
// top level of the decimal string to fixed point parser
//
// input channel: one character word per handshake (ch, has_char, last) on
// in_valid / in_ready; a word with has_char low carries no character.
// output channel: one result word (value, status) per text, on out_valid /
// out_ready, given after the word marked last.
// configuration: cfg_wr_en writes cfg_wr_data into the precision register.
// sequencing: each input word is accepted in the idle state, then applied
// in the char state (one pass through the shared times-ten unit); no new
// word is taken until the block is back in idle. after the word marked
// last, the block runs (effective precision - fraction digits) scaling
// steps on the same unit, leaves the loop in the scale state, then loads
// the output register in its finish step. a text already in error skips
// scaling and goes straight to the finish step; overflow ends the scaling
// early.
// the result sits in an output register, so the next text can start while
// it waits; if the receiver stalls with a result still held, the block
// waits in its finish step before loading the next one.
// reset: precision returns to 8, the parse state clears, no result pending.
module decimal_string_to_fixed_point (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          ch,
    input  logic                                has_char,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [dsfp_pkg::VALUE_W-1:0] value,
    output logic [dsfp_pkg::STATUS_W-1:0]       status,
    input  logic                                cfg_wr_en,
    input  logic [dsfp_pkg::PREC_W-1:0]         cfg_wr_data
);
    import dsfp_pkg::*;
    `include "decimal_string_to_fixed_point_macros.svh"

    dsfp_state_t state_reg, state_next;

    logic [PREC_W-1:0]   precision_reg;
    logic [7:0]          ch_reg;
    logic                has_char_reg;
    logic                last_reg;
    logic [ACC_W-1:0]    accum_reg, accum_next;
    logic [CNT_W-1:0]    digit_count_reg, digit_count_next;
    logic [CNT_W-1:0]    fraction_count_reg, fraction_count_next;
    logic [CNT_W-1:0]    scale_cnt_reg, scale_cnt_next;
    logic                point_seen_reg, point_seen_next;
    logic                is_negative_reg, is_negative_next;
    logic                at_first_reg, at_first_next;
    logic                skipping_reg, skipping_next;
    logic                body_seen_reg, body_seen_next;
    logic [STATUS_W-1:0] error_reg, error_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [PREC_W-1:0]   eff_prec;
    logic [3:0]          unit_digit;
    logic [ACC_W-1:0]    unit_y;
    logic                in_accept;

    assign in_accept = in_valid && in_ready;

    assign eff_prec = (precision_reg == '0) ? PREC_W'(1) :
                      (precision_reg > PREC_MAX) ? PREC_MAX : precision_reg;

    assign unit_digit = (state_reg == ST_CHAR) ? 4'(ch_reg - CHAR_ZERO) : 4'd0;

    dsfp_mul10_add u_mul10 (
        .a     (accum_reg),
        .digit (unit_digit),
        .y     (unit_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            precision_reg      <= PREC_RESET;
            accum_reg          <= '0;
            digit_count_reg    <= '0;
            fraction_count_reg <= '0;
            scale_cnt_reg      <= '0;
            point_seen_reg     <= 1'b0;
            is_negative_reg    <= 1'b0;
            at_first_reg       <= 1'b1;
            skipping_reg       <= 1'b1;
            body_seen_reg      <= 1'b0;
            error_reg          <= STATUS_OK;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                precision_reg <= cfg_wr_data;
            end
            accum_reg          <= accum_next;
            digit_count_reg    <= digit_count_next;
            fraction_count_reg <= fraction_count_next;
            scale_cnt_reg      <= scale_cnt_next;
            point_seen_reg     <= point_seen_next;
            is_negative_reg    <= is_negative_next;
            at_first_reg       <= at_first_next;
            skipping_reg       <= skipping_next;
            body_seen_reg      <= body_seen_next;
            error_reg          <= error_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ch_reg       <= ch;
            has_char_reg <= has_char;
            last_reg     <= last;
        end
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        logic                more;
        logic [CNT_W-1:0]    dc_inc;
        logic [CNT_W-1:0]    fc_inc;
        logic [STATUS_W-1:0] final_st;
        logic [VALUE_W-1:0]  mag;

        state_next          = state_reg;
        accum_next          = accum_reg;
        digit_count_next    = digit_count_reg;
        fraction_count_next = fraction_count_reg;
        scale_cnt_next      = scale_cnt_reg;
        point_seen_next     = point_seen_reg;
        is_negative_next    = is_negative_reg;
        at_first_next       = at_first_reg;
        skipping_next       = skipping_reg;
        body_seen_next      = body_seen_reg;
        error_next          = error_reg;
        value_next          = value_reg;
        status_next         = status_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        in_ready            = 1'b0;
        more                = 1'b0;
        dc_inc              = digit_count_reg + CNT_W'(1);
        fc_inc              = fraction_count_reg + CNT_W'(1);
        final_st            = error_reg;
        mag                 = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_CHAR;
                end
            end
            ST_CHAR:
            begin
                if (has_char_reg && error_reg == STATUS_OK)
                begin
                    more = 1'b1;
                    if (at_first_reg)
                    begin
                        at_first_next = 1'b0;
                        if (ch_reg == CHAR_MINUS)
                        begin
                            is_negative_next = 1'b1;
                            more = 1'b0;
                        end
                        else if (ch_reg == CHAR_PLUS)
                        begin
                            more = 1'b0;
                        end
                    end
                    if (more)
                    begin
                        body_seen_next = 1'b1;
                        if (!(skipping_reg && ch_reg == CHAR_ZERO))
                        begin
                            skipping_next = 1'b0;
                            if (ch_reg == CHAR_POINT)
                            begin
                                if (point_seen_reg)
                                begin
                                    error_next = STATUS_DOUBLE_POINT;
                                end
                                else
                                begin
                                    point_seen_next = 1'b1;
                                end
                            end
                            else if (ch_reg >= CHAR_ZERO && ch_reg <= CHAR_NINE)
                            begin
                                digit_count_next = dc_inc;
                                if (dc_inc > CNT_W'(MAX_DIGITS))
                                begin
                                    error_next = STATUS_TOO_MANY_DIG;
                                end
                                else if (point_seen_reg && fc_inc > eff_prec)
                                begin
                                    fraction_count_next = fc_inc;
                                    error_next = STATUS_TOO_MANY_FRAC;
                                end
                                else
                                begin
                                    if (point_seen_reg)
                                    begin
                                        fraction_count_next = fc_inc;
                                    end
                                    accum_next = unit_y;
                                end
                            end
                            else
                            begin
                                error_next = STATUS_BAD_CHAR;
                            end
                        end
                    end
                end
                if (last_reg)
                begin
                    if (error_next == STATUS_OK && !body_seen_next)
                    begin
                        error_next = STATUS_EMPTY;
                    end
                    scale_cnt_next = fraction_count_next;
                    state_next = (error_next == STATUS_OK) ? ST_SCALE : ST_FINISH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCALE:
            begin
                if (scale_cnt_reg >= eff_prec)
                begin
                    state_next = ST_FINISH;
                end
                else if (accum_reg > MAG_LIMIT_DIV10)
                begin
                    error_next = STATUS_OVERFLOW;
                    state_next = ST_FINISH;
                end
                else
                begin
                    accum_next     = unit_y;
                    scale_cnt_next = scale_cnt_reg + CNT_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (final_st == STATUS_OK && accum_reg > MAG_LIMIT)
                    begin
                        final_st = STATUS_OVERFLOW;
                    end
                    if (final_st == STATUS_OK)
                    begin
                        mag = {1'b0, accum_reg};
                    end
                    value_next          = is_negative_reg ? VALUE_W'(~mag + VALUE_W'(1)) : mag;
                    status_next         = final_st;
                    out_valid_next      = 1'b1;
                    accum_next          = '0;
                    digit_count_next    = '0;
                    fraction_count_next = '0;
                    point_seen_next     = 1'b0;
                    is_negative_next    = 1'b0;
                    at_first_next       = 1'b1;
                    skipping_next       = 1'b1;
                    body_seen_next      = 1'b0;
                    error_next          = STATUS_OK;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    `DSFP_ASSERT_IMP(a_err_value_zero, clk, rst_n,
        out_valid && status != STATUS_OK, value == '0, "error result with nonzero value")
    `DSFP_ASSERT_NEXT(a_accept_to_char, clk, rst_n,
        in_accept, state_reg == ST_CHAR, "accepted word not applied next cycle")
    `DSFP_ASSERT_IMP(a_scale_no_error, clk, rst_n,
        state_reg == ST_SCALE, error_reg == STATUS_OK && digit_count_reg <= CNT_W'(MAX_DIGITS),
        "scaling with an error or too many digits")

endmodule
